/* design/unsorted_priority_queue_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the unsorted priority queue
// Shorthand for the clocked checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef UNSORTED_PRIORITY_QUEUE_MACROS_SVH
`define UNSORTED_PRIORITY_QUEUE_MACROS_SVH

// Implication in the same cycle, off while reset is asserted.
`define UPQ_ASSERT_HOLD(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check the cycle after reset is seen low.
`define UPQ_ASSERT_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

/* design/upq_pkg.sv */
// ----------------------------------------------------------------------------
// upq_pkg
// Shared types and codes of the unsorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package upq_pkg;

  // Command field codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  // Classified operation kinds passed from front to back
  localparam logic [1:0] OP_INSERT    = 2'd0;
  localparam logic [1:0] OP_DELETE    = 2'd1;
  localparam logic [1:0] OP_OVERFLOW  = 2'd2;
  localparam logic [1:0] OP_UNDERFLOW = 2'd3;

  // Configuration register indexes
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [4:0] CAPACITY_RESET = 5'd5;

  // Command queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef logic [4:0] fill_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [31:0] item_priority;
  } op_t;

endpackage

`default_nettype wire

/* design/unsorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// unsorted_priority_queue
// Bounded priority queue on an unsorted store with a minimum scan on delete.
// ----------------------------------------------------------------------------
// Raise start with a command while busy is low; the beat is taken at that
// edge. Each command gives exactly one result beat, shown on the out_ ports
// for a single cycle with out_valid high; the receiver cannot hold it off,
// so sample it then. An insert, an overflow or an underflow waits in the
// command queue while the back end is busy and is handled in the back
// end's idle state; its result is registered. A successful delete over n
// stored entries first scans them all for the smallest priority, then
// shifts the entries above it down to close the gap; the entry store has
// a single read port. A command queue of two beats lets new commands be
// taken while a delete is running; busy rises only when that queue is
// full. The capacity register (byte address 0) may only be written while
// no command is outstanding.
// ----------------------------------------------------------------------------
`default_nettype none

module unsorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // command channel
  input  wire logic         start,
  output logic              busy,
  input  wire logic         in_cmd,
  input  wire logic [31:0]  in_value,
  input  wire logic [31:0]  in_item_priority,
  // result channel
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [31:0]       out_value,
  output logic [31:0]       out_priority,
  output logic [4:0]        out_fill_count,
  // configuration port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [4:0]    capacity_r;
  logic          cfg_wr;
  logic          cfg_sel_cap;

  logic          q_push, q_pop, q_full, q_empty;
  upq_pkg::op_t  front_op, head_op;

  // Configuration: one register, word index in paddr[2]
  assign pready      = 1'b1;
  assign cfg_sel_cap = (paddr[2] == upq_pkg::REG_CAPACITY);
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign prdata      = cfg_sel_cap ? 32'(capacity_r) : 32'd0;

  // Hold the capacity; only its low five bits are kept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= upq_pkg::CAPACITY_RESET;
    end else if (cfg_wr && cfg_sel_cap) begin
      capacity_r <= pwdata[4:0];
    end
  end

  // Front: classify each command against the projected count
  upq_front #(
    .DEPTH(DEPTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .cmd           (in_cmd),
    .value         (in_value),
    .item_priority (in_item_priority),
    .capacity      (capacity_r),
    .q_full        (q_full),
    .busy          (busy),
    .push          (q_push),
    .op            (front_op)
  );

  // Queue: decouple acceptance from the long delete sequence
  upq_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (front_op),
    .pop     (q_pop),
    .head_op (head_op),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Back: store, scan, shift and drive the result beat
  upq_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_op        (head_op),
    .q_empty        (q_empty),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_value      (out_value),
    .out_priority   (out_priority),
    .out_fill_count (out_fill_count)
  );

endmodule

`default_nettype wire

/* design/upq_front.sv */
// ----------------------------------------------------------------------------
// upq_front
// Accepts commands, tracks the projected fill count and classifies each beat.
// ----------------------------------------------------------------------------
`default_nettype none

module upq_front #(
  parameter int DEPTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic           cmd,
  input  wire logic [31:0]    value,
  input  wire logic [31:0]    item_priority,
  input  wire logic [4:0]     capacity,
  input  wire logic           q_full,
  output logic                busy,
  output logic                push,
  output upq_pkg::op_t        op
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          at_limit;

  // Full when the count reaches the capacity or the built depth
  assign at_limit = (count_r >= CW'(DEPTH)) || (32'(count_r) >= 32'(capacity));

  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    op.value         = value;
    op.item_priority = item_priority;
    count_nxt        = count_r;
    if (cmd == upq_pkg::CMD_INSERT) begin
      if (at_limit) begin
        op.kind = upq_pkg::OP_OVERFLOW;
      end else begin
        op.kind   = upq_pkg::OP_INSERT;
        count_nxt = count_r + CW'(1);
      end
    end else begin
      if (count_r == '0) begin
        op.kind = upq_pkg::OP_UNDERFLOW;
      end else begin
        op.kind   = upq_pkg::OP_DELETE;
        count_nxt = count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (push) begin
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/upq_cmd_queue.sv */
// ----------------------------------------------------------------------------
// upq_cmd_queue
// Short queue of classified operations between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module upq_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire upq_pkg::op_t  push_op,
  input  wire logic          pop,
  output upq_pkg::op_t       head_op,
  output logic               full,
  output logic               empty
);

  upq_pkg::op_t                entry_r [upq_pkg::QUEUE_DEPTH];
  logic [upq_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [upq_pkg::QPTR_W:0]    used_r;
  logic                        do_push, do_pop;

  assign full    = (used_r == (upq_pkg::QPTR_W + 1)'(upq_pkg::QUEUE_DEPTH));
  assign empty   = (used_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head_op = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      used_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        used_r <= used_r + 1'b1;
      end else if (do_pop && !do_push) begin
        used_r <= used_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/upq_back.sv */
// ----------------------------------------------------------------------------
// upq_back
// Holds the entry store, runs the minimum scan and the shift, drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module upq_back #(
  parameter int DEPTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire upq_pkg::op_t   head_op,
  input  wire logic           q_empty,
  output logic                pop,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [31:0]         out_value,
  output logic [31:0]         out_priority,
  output logic [4:0]          out_fill_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  // Store word: value in the upper half, priority in the lower half
  logic [63:0]   mem [DEPTH];

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ra_r, ra_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic [63:0]   rd_data_r;
  logic [IW-1:0] best_idx_r, best_idx_nxt;
  logic [63:0]   best_pair_r, best_pair_nxt;

  logic          mem_re, mem_we;
  logic [IW-1:0] mem_wa;
  logic [63:0]   mem_wd;

  logic          emit;
  logic [1:0]    st_nxt;
  logic [31:0]   val_nxt, pri_nxt;
  logic [CW-1:0] fill_nxt;

  logic          take;
  logic          last_rd;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [31:0]   out_value_r, out_priority_r;
  logic [4:0]    out_fill_r;

  assign take    = (rd_idx_r == '0) ||
                   ($signed(rd_data_r[31:0]) < $signed(best_pair_r[31:0]));
  assign last_rd = ((CW'(rd_idx_r) + CW'(1)) == count_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ra_nxt        = ra_r;
    rd_idx_nxt    = rd_idx_r;
    best_idx_nxt  = best_idx_r;
    best_pair_nxt = best_pair_r;
    pop           = 1'b0;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = count_r[IW-1:0];
    mem_wd        = {head_op.value, head_op.item_priority};
    emit          = 1'b0;
    st_nxt        = upq_pkg::ST_OK;
    val_nxt       = '0;
    pri_nxt       = '0;
    fill_nxt      = count_r;

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          case (head_op.kind)
            upq_pkg::OP_INSERT: begin
              mem_we    = 1'b1;
              count_nxt = count_r + CW'(1);
              fill_nxt  = count_r + CW'(1);
              emit      = 1'b1;
            end
            upq_pkg::OP_DELETE: begin
              ra_nxt    = '0;
              state_nxt = S_SCAN;
            end
            upq_pkg::OP_OVERFLOW: begin
              st_nxt = upq_pkg::ST_OVERFLOW;
              emit   = 1'b1;
            end
            default: begin
              st_nxt = upq_pkg::ST_UNDERFLOW;
              emit   = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Stream reads of every stored entry, compare as the data returns
        mem_re = (ra_r < count_r);
        if (mem_re) begin
          ra_nxt     = ra_r + CW'(1);
          rd_idx_nxt = ra_r[IW-1:0];
        end
        if (rd_vld_r) begin
          if (take) begin
            best_idx_nxt  = rd_idx_r;
            best_pair_nxt = rd_data_r;
          end
          if (last_rd) begin
            ra_nxt    = CW'(best_idx_nxt) + CW'(1);
            state_nxt = S_SHIFT;
          end
        end
      end

      S_SHIFT: begin
        // Read entry k, write it back at k-1 in the cycle after
        mem_re = (ra_r < count_r);
        if (mem_re) begin
          ra_nxt     = ra_r + CW'(1);
          rd_idx_nxt = ra_r[IW-1:0];
        end
        if (rd_vld_r) begin
          mem_we = 1'b1;
          mem_wa = rd_idx_r - IW'(1);
          mem_wd = rd_data_r;
        end
        if (!mem_re && !rd_vld_r) begin
          count_nxt = count_r - CW'(1);
          fill_nxt  = count_r - CW'(1);
          val_nxt   = best_pair_r[63:32];
          pri_nxt   = best_pair_r[31:0];
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign rd_vld_nxt = mem_re;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[ra_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    ra_r        <= ra_nxt;
    rd_idx_r    <= rd_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_pair_r <= best_pair_nxt;
    if (emit) begin
      out_status_r   <= st_nxt;
      out_value_r    <= val_nxt;
      out_priority_r <= pri_nxt;
      out_fill_r     <= upq_pkg::fill_t'(fill_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_value      = out_value_r;
  assign out_priority   = out_priority_r;
  assign out_fill_count = out_fill_r;

endmodule

`default_nettype wire

/* design/upq_checker.sv */
// ----------------------------------------------------------------------------
// upq_checker
// Port-level checks on result beats of the unsorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "unsorted_priority_queue_macros.svh"

module upq_checker #(
  parameter int DEPTH = 16
) (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         busy,
  input wire logic         out_valid,
  input wire logic [1:0]   out_status,
  input wire logic [31:0]  out_value,
  input wire logic [31:0]  out_priority,
  input wire logic [4:0]   out_fill_count
);

  `UPQ_ASSERT_HOLD(a_status_legal, out_valid, (out_status == upq_pkg::ST_OK) || (out_status == upq_pkg::ST_OVERFLOW) || (out_status == upq_pkg::ST_UNDERFLOW), "result beat with an unknown status")

  `UPQ_ASSERT_HOLD(a_error_zero, out_valid && (out_status != upq_pkg::ST_OK), (out_value == 32'd0) && (out_priority == 32'd0), "failed command returned a non-zero entry")

  `UPQ_ASSERT_HOLD(a_underflow_empty, out_valid && (out_status == upq_pkg::ST_UNDERFLOW), (out_fill_count == 5'd0) && (32'(out_fill_count) <= DEPTH), "underflow reported with entries stored")

  `UPQ_ASSERT_RESET(a_reset_quiet, !out_valid && !busy, "result or busy left set after reset")

endmodule

bind unsorted_priority_queue upq_checker #(
  .DEPTH(DEPTH)
) u_upq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_value      (out_value),
  .out_priority   (out_priority),
  .out_fill_count (out_fill_count)
);

`default_nettype wire
